// ===== hw/rtl/oaht_pkg.sv =====
// Shared types and constants of the open addressing hash table.
// Holds the request and response beat types, action and slot codes.
// No dependencies.
package oaht_pkg;

	localparam int SLOTS_DEF      = 1024;
	localparam int KEY_BITS_DEF   = 32;
	localparam int VALUE_BITS_DEF = 32;
	localparam int LIMIT_W        = 11;

	// Request actions.
	localparam logic [1:0] ACT_SEARCH = 2'd0;
	localparam logic [1:0] ACT_INSERT = 2'd1;
	localparam logic [1:0] ACT_DELETE = 2'd2;

	// Slot state codes; any other code counts as a tombstone.
	localparam logic [1:0] SLOT_EMPTY = 2'd0;
	localparam logic [1:0] SLOT_LIVE  = 2'd1;
	localparam logic [1:0] SLOT_TOMB  = 2'd2;

	typedef struct packed {
		logic [1:0]         action;
		logic signed [31:0] hash;
		logic [31:0]        key;
		logic [31:0]        value;
	} req_t;

	typedef struct packed {
		logic        found;
		logic [31:0] result_value;
		logic        status;
	} rsp_t;

endpackage

// ===== hw/rtl/open_addressing_hash_table.sv =====
// Open addressing hash table with quadratic then linear probing and tombstones.
// Steps: the hash is reduced in S_MOD, each probe passes an address and an evaluate state, then S_FIN hands over.
// One request at a time; the shared slot memory port sets the probe rate.
// Reset: a sweep over every slot empties the table; every 255 requests a
// sweep over every slot clears the visit marks. No request is taken meanwhile.
// Depends on oaht_pkg.
module open_addressing_hash_table #(
	parameter int SLOTS      = oaht_pkg::SLOTS_DEF,
	parameter int KEY_BITS   = oaht_pkg::KEY_BITS_DEF,
	parameter int VALUE_BITS = oaht_pkg::VALUE_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [oaht_pkg::LIMIT_W-1:0]   cfg_wdata,
	input  logic                           req_valid,
	output logic                           req_ready,
	input  oaht_pkg::req_t                 req,
	output logic                           rsp_valid,
	input  logic                           rsp_ready,
	output oaht_pkg::rsp_t                 rsp
);
	import oaht_pkg::*;

	localparam int SW     = (SLOTS > 2) ? $clog2(SLOTS) : 1;
	localparam int LW     = (SW + 1 > LIMIT_W) ? SW + 1 : LIMIT_W;
	localparam int SQ     = (SLOTS - 1) / 2;
	localparam int CAP    = SQ + 2 * SLOTS;
	localparam int IW     = $clog2(CAP + 1);
	localparam int QW     = 2 * SW;
	localparam int XW     = 34;
	localparam int EPW    = 8;
	localparam longint C31 = (64'sd1 <<< 31) % SLOTS;
	localparam int LRST   = ((3 * SLOTS / 4) > 2047) ? 2047 : (3 * SLOTS / 4);
	localparam logic [31:0] RECIP = 32'((64'd1 << 32) / SLOTS);

	localparam logic [2:0] S_SWEEP = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_MOD   = 3'd2;
	localparam logic [2:0] S_FADDR = 3'd3;
	localparam logic [2:0] S_FEVAL = 3'd4;
	localparam logic [2:0] S_IADDR = 3'd5;
	localparam logic [2:0] S_IEVAL = 3'd6;
	localparam logic [2:0] S_FIN   = 3'd7;

	// Slot memories.
	logic [1:0]            state_mem [SLOTS];
	logic [31:0]           hash_mem  [SLOTS];
	logic [KEY_BITS-1:0]   key_mem   [SLOTS];
	logic [VALUE_BITS-1:0] value_mem [SLOTS];
	logic [EPW-1:0]        seen_mem  [SLOTS];

	logic [1:0]            rd_state_q;
	logic [31:0]           rd_hash_q;
	logic [KEY_BITS-1:0]   rd_key_q;
	logic [VALUE_BITS-1:0] rd_value_q;
	logic [EPW-1:0]        rd_seen_q;

	logic [2:0]            st_q;
	logic                  sweep_all_q;
	logic [SW-1:0]         idx_q;
	logic [EPW-1:0]        epoch_q;
	logic [LIMIT_W-1:0]    limit_q;
	logic [LW-1:0]         live_q;
	logic [LW-1:0]         seen_q;
	logic [LW-1:0]         target_q;
	logic                  mod_ph_q;
	logic [31:0]           qe_q;
	logic [SW-1:0]         r0_q;

	logic [1:0]            act_q;
	logic signed [31:0]    h_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] val_q;

	// Probe generator registers.
	logic [IW-1:0]         i_q;
	logic [SW-1:0]         q_q;
	logic [QW-1:0]         qsq_q;
	logic [SW-1:0]         rp_q;
	logic [SW-1:0]         rn_q;
	logic signed [XW-1:0]  x_q;
	logic [SW-1:0]         r_q;
	logic [SW-1:0]         addr_q;

	logic                  res_found_q;
	logic [31:0]           res_val_q;
	logic                  res_status_q;
	logic                  rsp_valid_q;
	rsp_t                  rsp_q;

	// Reduction of the biased hash: a reciprocal multiply gives a quotient that
	// is at most one low, so one compare and subtract finishes the residue.
	logic [31:0]           hu;
	logic [63:0]           prod;
	logic [31:0]           qs;
	logic [31:0]           rm;
	logic [SW-1:0]         rr_nx;
	logic signed [SW+1:0]  r0_d;
	logic [SW-1:0]         r0_nx;

	always_comb begin
		hu    = h_q ^ 32'h8000_0000;
		prod  = {32'd0, hu} * {32'd0, RECIP};
		qs    = qe_q * 32'(SLOTS);
		rm    = hu - qs;
		rr_nx = (rm >= 32'(SLOTS)) ? SW'(rm - 32'(SLOTS)) : SW'(rm);
		r0_d  = $signed({2'b00, rr_nx}) - $signed((SW+2)'(C31));
		r0_nx = (r0_d < 0) ? SW'(r0_d + $signed((SW+2)'(SLOTS))) : SW'(r0_d);
	end

	// Next probe position: exact offset sum and its residue modulo SLOTS.
	logic [IW-1:0]         ni;
	logic [SW:0]           dd;
	logic [SW+1:0]         rp_sum;
	logic [SW-1:0]         rp_nx;
	logic signed [SW+1:0]  rn_dif;
	logic [SW-1:0]         rn_nx;
	logic [QW-1:0]         qsq_nx;
	logic [SW+1:0]         rl_sum;
	logic [SW-1:0]         rl_nx;
	logic signed [XW-1:0]  hx;
	logic signed [XW-1:0]  x_nx;
	logic [SW-1:0]         r_nx;
	logic                  sq_step;

	always_comb begin
		ni      = i_q + IW'(1);
		dd      = {q_q, 1'b1};
		rp_sum  = {1'b0, rp_q} + {1'b0, dd};
		rp_nx   = (rp_sum >= (SW+2)'(SLOTS)) ? SW'(rp_sum - (SW+2)'(SLOTS)) : SW'(rp_sum);
		rn_dif  = $signed({2'b00, rn_q}) - $signed({1'b0, dd});
		rn_nx   = (rn_dif < 0) ? SW'(rn_dif + $signed((SW+2)'(SLOTS))) : SW'(rn_dif);
		qsq_nx  = qsq_q + QW'(dd);
		// Entering the linear phase restarts from the residue of the hash plus SQ.
		if (ni == IW'(SQ))
			rl_sum = {2'b00, r0_q} + (SW+2)'(SQ);
		else
			rl_sum = {2'b00, r_q} + (SW+2)'(1);
		rl_nx   = (rl_sum >= (SW+2)'(SLOTS)) ? SW'(rl_sum - (SW+2)'(SLOTS)) : SW'(rl_sum);
		hx      = XW'(h_q);
		sq_step = ni < IW'(SQ);
		if (sq_step && ni[0]) begin
			x_nx = hx + $signed(XW'(qsq_nx));
			r_nx = rp_nx;
		end else if (sq_step) begin
			x_nx = hx - $signed(XW'(qsq_q));
			r_nx = rn_q;
		end else begin
			x_nx = hx + $signed(XW'(ni));
			r_nx = rl_nx;
		end
	end

	// Slot index is the magnitude of the truncating remainder.
	logic [SW-1:0] slot;
	assign slot = (x_q[XW-1] && r_q != '0) ? SW'(SW'(SLOTS) - r_q) : r_q;

	// Probe evaluation.
	logic          is_empty;
	logic          is_match;
	logic          is_live;
	logic          new_mark;
	logic [LW-1:0] seen_nx;
	logic          walk_on;

	always_comb begin
		is_empty = rd_state_q == SLOT_EMPTY;
		is_live  = rd_state_q == SLOT_LIVE;
		is_match = is_live && rd_hash_q == h_q && rd_key_q == key_q;
		new_mark = rd_seen_q != epoch_q;
		seen_nx  = seen_q + LW'(new_mark);
		walk_on  = (seen_nx < target_q) && (ni < IW'(CAP));
	end

	// Memory write controls.
	logic                  state_we;
	logic [1:0]            state_wd;
	logic                  seen_we;
	logic                  entry_we;
	logic                  value_we;
	logic [SW-1:0]         waddr;

	always_comb begin
		state_we = 1'b0;
		state_wd = SLOT_LIVE;
		seen_we  = 1'b0;
		entry_we = 1'b0;
		value_we = 1'b0;
		waddr    = addr_q;
		case (st_q)
			S_SWEEP: begin
				waddr    = idx_q;
				seen_we  = 1'b1;
				state_we = sweep_all_q;
				state_wd = SLOT_EMPTY;
			end
			S_FEVAL: begin
				if (!is_empty && is_match) begin
					state_we = act_q == ACT_DELETE;
					state_wd = SLOT_TOMB;
					value_we = act_q == ACT_INSERT;
				end else if (!is_empty) begin
					seen_we = new_mark;
				end
			end
			S_IEVAL: begin
				entry_we = !is_live;
				state_we = !is_live;
				value_we = !is_live;
			end
			default: begin
				state_we = 1'b0;
			end
		endcase
	end

	// Slot memories: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (state_we)
			state_mem[waddr] <= state_wd;
		if (entry_we) begin
			hash_mem[waddr] <= h_q;
			key_mem[waddr]  <= key_q;
		end
		if (value_we)
			value_mem[waddr] <= val_q;
		if (seen_we)
			seen_mem[waddr] <= sweep_all_q && st_q == S_SWEEP ? '0 :
				(st_q == S_SWEEP ? '0 : epoch_q);
		rd_state_q <= state_mem[slot];
		rd_hash_q  <= hash_mem[slot];
		rd_key_q   <= key_mem[slot];
		rd_value_q <= value_mem[slot];
		rd_seen_q  <= seen_mem[slot];
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= S_SWEEP;
			sweep_all_q  <= 1'b1;
			idx_q        <= '0;
			epoch_q      <= EPW'(1);
			limit_q      <= LIMIT_W'(LRST);
			live_q       <= '0;
			seen_q       <= '0;
			target_q     <= '0;
			mod_ph_q     <= 1'b0;
			qe_q         <= '0;
			r0_q         <= '0;
			act_q        <= '0;
			h_q          <= '0;
			key_q        <= '0;
			val_q        <= '0;
			i_q          <= '0;
			q_q          <= '0;
			qsq_q        <= '0;
			rp_q         <= '0;
			rn_q         <= '0;
			x_q          <= '0;
			r_q          <= '0;
			addr_q       <= '0;
			res_found_q  <= 1'b0;
			res_val_q    <= '0;
			res_status_q <= 1'b0;
			rsp_valid_q  <= 1'b0;
			rsp_q        <= '0;
		end else begin
			if (cfg_we)
				limit_q <= cfg_wdata;
			if (rsp_valid_q && rsp_ready && st_q != S_FIN)
				rsp_valid_q <= 1'b0;

			case (st_q)
				S_SWEEP: begin
					idx_q <= idx_q + SW'(1);
					if (idx_q == SW'(SLOTS - 1)) begin
						st_q        <= S_IDLE;
						sweep_all_q <= 1'b0;
						epoch_q     <= EPW'(1);
					end
				end
				S_IDLE: begin
					if (req_valid) begin
						act_q        <= req.action;
						h_q          <= req.hash;
						key_q        <= KEY_BITS'(req.key);
						val_q        <= VALUE_BITS'(req.value);
						res_found_q  <= 1'b0;
						res_val_q    <= '0;
						res_status_q <= 1'b0;
						seen_q       <= '0;
						target_q     <= (req.action == ACT_INSERT) ? live_q : LW'(SLOTS);
						st_q         <= (req.action == ACT_SEARCH || req.action == ACT_INSERT ||
							req.action == ACT_DELETE) ? S_MOD : S_FIN;
					end
				end
				S_MOD: begin
					if (!mod_ph_q) begin
						// Quotient estimate from the reciprocal product.
						qe_q     <= prod[63:32];
						mod_ph_q <= 1'b1;
					end else begin
						mod_ph_q <= 1'b0;
						r0_q     <= r0_nx;
						i_q      <= '0;
						q_q      <= '0;
						qsq_q    <= '0;
						rp_q     <= r0_nx;
						rn_q     <= r0_nx;
						x_q      <= XW'(h_q);
						r_q      <= r0_nx;
						if (target_q != '0)
							st_q <= S_FADDR;
						else if (live_q >= LW'(limit_q)) begin
							res_status_q <= 1'b1;
							st_q         <= S_FIN;
						end else
							st_q <= S_IADDR;
					end
				end
				S_FADDR, S_IADDR: begin
					addr_q <= slot;
					st_q   <= (st_q == S_FADDR) ? S_FEVAL : S_IEVAL;
				end
				S_FEVAL: begin
					if (!is_empty && is_match) begin
						res_found_q <= 1'b1;
						res_val_q   <= 32'(rd_value_q);
						if (act_q == ACT_DELETE && live_q != '0)
							live_q <= live_q - LW'(1);
						st_q <= S_FIN;
					end else if (!is_empty && walk_on) begin
						seen_q <= seen_nx;
						i_q    <= ni;
						x_q    <= x_nx;
						r_q    <= r_nx;
						if (sq_step && ni[0]) begin
							q_q   <= q_q + SW'(1);
							qsq_q <= qsq_nx;
							rp_q  <= rp_nx;
							rn_q  <= rn_nx;
						end
						st_q <= S_FADDR;
					end else if (act_q == ACT_INSERT) begin
						// Key not present: store it unless at the load limit.
						i_q   <= '0;
						q_q   <= '0;
						qsq_q <= '0;
						rp_q  <= r0_q;
						rn_q  <= r0_q;
						x_q   <= XW'(h_q);
						r_q   <= r0_q;
						if (live_q >= LW'(limit_q)) begin
							res_status_q <= 1'b1;
							st_q         <= S_FIN;
						end else
							st_q <= S_IADDR;
					end else
						st_q <= S_FIN;
				end
				S_IEVAL: begin
					if (!is_live) begin
						live_q <= live_q + LW'(1);
						st_q   <= S_FIN;
					end else if (ni < IW'(CAP)) begin
						i_q <= ni;
						x_q <= x_nx;
						r_q <= r_nx;
						if (sq_step && ni[0]) begin
							q_q   <= q_q + SW'(1);
							qsq_q <= qsq_nx;
							rp_q  <= rp_nx;
							rn_q  <= rn_nx;
						end
						st_q <= S_IADDR;
					end else begin
						res_status_q <= 1'b1;
						st_q         <= S_FIN;
					end
				end
				S_FIN: begin
					// Hand the result over once the output register is free.
					if (!rsp_valid_q || rsp_ready) begin
						rsp_valid_q        <= 1'b1;
						rsp_q.found        <= res_found_q;
						rsp_q.result_value <= res_val_q;
						rsp_q.status       <= res_status_q;
						if (epoch_q == '1) begin
							idx_q <= '0;
							st_q  <= S_SWEEP;
						end else begin
							epoch_q <= epoch_q + EPW'(1);
							st_q    <= S_IDLE;
						end
					end
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req_ready = st_q == S_IDLE;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== hw/rtl/oaht_checker.sv =====
// Port-level checks of the open addressing hash table, bound to its top level.
// Depends on oaht_pkg and open_addressing_hash_table.
module oaht_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_ready,
	input oaht_pkg::req_t req,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input oaht_pkg::rsp_t rsp
);
	import oaht_pkg::*;

	// A rejected insert never reports a match.
	a_full_not_found: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp.status && rsp.found))
		else $error("status full together with found");

	// Without a match the returned value is zero.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.found |-> rsp.result_value == 32'd0)
		else $error("nonzero value without a match");

	// Requests are served one at a time, so ready drops after each accepted beat.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("ready stayed high after an accepted beat");

	// A stalled response beat holds.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response beat changed while stalled");

endmodule

bind open_addressing_hash_table oaht_checker u_oaht_checker (.*);

// ===== verif/tb_top.sv =====
// Self-checking testbench for the open addressing hash table.
// A driver, a receiver and a monitor run as clocked processes. An initial block
// fills the queue of pending requests and a table model predicts each response.
// Depends on oaht_pkg and open_addressing_hash_table.
module tb_top;
	import oaht_pkg::*;

	localparam int NSLOT       = 1024;
	localparam int SQ_END      = (NSLOT - 1) / 2;
	localparam int WALK_CAP    = SQ_END + 2 * NSLOT;
	localparam int STALL_LIMIT = 40000;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [LIMIT_W-1:0]   cfg_wdata;
	logic                 req_valid;
	logic                 req_ready;
	req_t                 req;
	logic                 rsp_valid;
	logic                 rsp_ready;
	rsp_t                 rsp;

	// Table model: slot contents, live entry count and the load limit.
	logic [1:0]         mdl_state [NSLOT];
	logic [31:0]        mdl_hash  [NSLOT];
	logic [31:0]        mdl_key   [NSLOT];
	logic [31:0]        mdl_value [NSLOT];
	int unsigned        mdl_live;
	int unsigned        mdl_limit;

	req_t req_pending [$];
	rsp_t rsp_expected [$];
	logic [31:0] key_pool [40];

	int  sent_cnt;
	int  done_cnt;
	int  err_cnt;
	int  hit_cnt;
	int  full_cnt;
	int  idle_cycles;
	bit  req_taken;
	bit  quiet;
	bit  sender_hold;
	bit  long_hold;
	int  req_gap;
	int  rsp_gap;
	int  hold_left;

	open_addressing_hash_table u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Slot visited at probe step i: quadratic offsets first, then linear.
	function automatic int unsigned probe_at(logic signed [31:0] h, int unsigned i);
		longint off;
		longint q;
		longint r;
		if (i < SQ_END) begin
			if (i == 0) begin
				off = 0;
			end else if (i[0]) begin
				q = (i + 1) / 2;
				off = q * q;
			end else begin
				q = i / 2;
				off = -(q * q);
			end
		end else begin
			off = i;
		end
		r = (longint'(h) + off) % NSLOT;
		if (r < 0)
			r = -r;
		return int'(r);
	endfunction

	// Walks the probe sequence; returns the matching slot or -1.
	function automatic int locate(logic signed [31:0] h, logic [31:0] k, int unsigned target);
		bit          seen [NSLOT];
		int unsigned distinct;
		int unsigned s;
		distinct = 0;
		for (int unsigned i = 0; distinct < target && i < WALK_CAP; i++) begin
			s = probe_at(h, i);
			if (mdl_state[s] == SLOT_EMPTY)
				return -1;
			if (mdl_state[s] == SLOT_LIVE && mdl_hash[s] == h && mdl_key[s] == k)
				return int'(s);
			if (!seen[s]) begin
				seen[s] = 1'b1;
				distinct++;
			end
		end
		return -1;
	endfunction

	// Applies one request to the model and returns the response it gives.
	function automatic rsp_t table_response(req_t r);
		rsp_t        o;
		int          hit;
		int unsigned s;
		o = '0;
		if (r.action == ACT_SEARCH || r.action == ACT_DELETE) begin
			hit = locate($signed(r.hash), r.key, NSLOT);
			if (hit >= 0) begin
				o.found = 1'b1;
				o.result_value = mdl_value[hit];
				if (r.action == ACT_DELETE) begin
					mdl_state[hit] = SLOT_TOMB;
					if (mdl_live > 0)
						mdl_live--;
				end
			end
		end else if (r.action == ACT_INSERT) begin
			hit = locate($signed(r.hash), r.key, mdl_live);
			if (hit >= 0) begin
				o.found = 1'b1;
				o.result_value = mdl_value[hit];
				mdl_value[hit] = r.value;
			end else begin
				o.status = 1'b1;
				if (mdl_live < mdl_limit) begin
					for (int unsigned i = 0; i < WALK_CAP; i++) begin
						s = probe_at($signed(r.hash), i);
						if (mdl_state[s] != SLOT_LIVE) begin
							mdl_state[s] = SLOT_LIVE;
							mdl_hash[s] = r.hash;
							mdl_key[s] = r.key;
							mdl_value[s] = r.value;
							mdl_live++;
							o.status = 1'b0;
							break;
						end
					end
				end
			end
		end
		return o;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch on response %0d: %s got %h expected %h", done_cnt, what, got, want);
		err_cnt++;
	endtask

	task automatic add_req(logic [1:0] act, logic [31:0] h, logic [31:0] k, logic [31:0] v);
		req_t r;
		r.action = act;
		r.hash = h;
		r.key = k;
		r.value = v;
		req_pending.push_back(r);
		sent_cnt++;
	endtask

	// Random request: mostly pool keys with their usual hash, some odd hashes and noise.
	task automatic add_random_req();
		int          sel;
		int          pick;
		logic [1:0]  act;
		logic [31:0] k;
		logic [31:0] h;
		sel = $urandom_range(99);
		pick = $urandom_range(99);
		act = (pick < 45) ? ACT_INSERT : (pick < 75) ? ACT_SEARCH :
			(pick < 95) ? ACT_DELETE : 2'd3;
		k = key_pool[$urandom_range(39)];
		h = k * 32'h9E3779B1;
		if (sel >= 95) begin
			k = $urandom;
			h = $urandom;
		end else if (sel >= 85) begin
			h = $urandom;
		end
		add_req(act, h, k, $urandom);
	endtask

	task automatic wait_drained();
		while (done_cnt != sent_cnt || req_pending.size() != 0)
			@(negedge clk);
	endtask

	task automatic set_limit(int unsigned v);
		wait_drained();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v[LIMIT_W-1:0];
		mdl_limit = v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Driver: offers the next pending beat, with random gaps.
	always @(negedge clk) begin
		if (!(req_valid && !req_taken)) begin
			req_taken = 1'b0;
			if (req_gap > 0 && !quiet) begin
				req_gap--;
				req_valid <= 1'b0;
			end else if (req_pending.size() != 0 && !sender_hold) begin
				req <= req_pending.pop_front();
				req_valid <= 1'b1;
				if (!quiet && $urandom_range(9) == 0)
					req_gap = $urandom_range(1, 10);
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// Receiver: random stall bursts, plus one long hold-off on request.
	always @(negedge clk) begin
		if (long_hold && hold_left == 0)
			hold_left = 400;
		if (hold_left > 0) begin
			hold_left--;
			if (hold_left == 0)
				long_hold = 1'b0;
			rsp_ready <= 1'b0;
		end else if (rsp_gap > 0 && !quiet) begin
			rsp_gap--;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= 1'b1;
			if (!quiet && $urandom_range(7) == 0)
				rsp_gap = $urandom_range(1, 10);
		end
	end

	// Monitor: predicts on each accepted request beat, checks each response beat.
	always @(posedge clk) begin
		rsp_t want;
		bit   moved;
		moved = 1'b0;
		if (arst_n) begin
			if (req_valid && req_ready) begin
				rsp_expected.push_back(table_response(req));
				req_taken = 1'b1;
				moved = 1'b1;
			end
			if (rsp_valid && rsp_ready) begin
				moved = 1'b1;
				if (rsp_expected.size() == 0) begin
					$display("response beat with no request outstanding");
					err_cnt++;
				end else begin
					want = rsp_expected.pop_front();
					if (rsp.found !== want.found)
						report_mismatch("found", rsp.found, want.found);
					if (rsp.result_value !== want.result_value)
						report_mismatch("result_value", rsp.result_value, want.result_value);
					if (rsp.status !== want.status)
						report_mismatch("status", rsp.status, want.status);
					hit_cnt += want.found;
					full_cnt += want.status;
				end
				done_cnt++;
			end
			// Watchdog on cycles without any accepted beat while work is outstanding.
			if (moved || (done_cnt == sent_cnt && req_pending.size() == 0))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("open_addressing_hash_table regression: fail");
				$finish;
			end
		end
	end

	initial begin
		cfg_we = 1'b0;
		cfg_wdata = '0;
		req_valid = 1'b0;
		req = '0;
		rsp_ready = 1'b0;
		req_taken = 1'b0;
		quiet = 1'b0;
		sender_hold = 1'b0;
		long_hold = 1'b0;
		req_gap = 0;
		rsp_gap = 0;
		hold_left = 0;
		sent_cnt = 0;
		done_cnt = 0;
		err_cnt = 0;
		hit_cnt = 0;
		full_cnt = 0;
		idle_cycles = 0;
		mdl_live = 0;
		mdl_limit = 768;
		for (int i = 0; i < NSLOT; i++) begin
			mdl_state[i] = SLOT_EMPTY;
			mdl_hash[i] = '0;
			mdl_key[i] = '0;
			mdl_value[i] = '0;
		end
		for (int i = 0; i < 40; i++)
			key_pool[i] = $urandom;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: field extremes, every action, replace, misses, unused action code.
		add_req(ACT_INSERT, 32'h8000_0000, 32'h0000_0000, 32'h0000_0000);
		add_req(ACT_INSERT, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		add_req(ACT_SEARCH, 32'h8000_0000, 32'h0000_0000, 32'h1234_5678);
		add_req(ACT_SEARCH, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0);
		add_req(ACT_INSERT, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hA5A5_5A5A);
		add_req(ACT_INSERT, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001);
		add_req(ACT_SEARCH, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0);
		add_req(ACT_DELETE, 32'h8000_0000, 32'h0000_0000, 32'h0);
		add_req(ACT_SEARCH, 32'h8000_0000, 32'h0000_0000, 32'h0);
		add_req(ACT_DELETE, 32'h8000_0000, 32'h0000_0000, 32'h0);
		add_req(ACT_INSERT, 32'h8000_0000, 32'h0000_0000, 32'h5555_AAAA);
		add_req(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		add_req(ACT_SEARCH, 32'h0000_0400, 32'h0000_0000, 32'h0);
		add_req(ACT_INSERT, 32'h0000_0400, 32'h0000_0000, 32'hDEAD_BEEF);
		add_req(ACT_SEARCH, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0);

		// Zero limit: new keys are refused, stored keys are still replaced.
		set_limit(0);
		add_req(ACT_INSERT, 32'h0000_0055, 32'h0000_0055, 32'h1);
		add_req(ACT_INSERT, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h2);
		add_req(ACT_SEARCH, 32'h0000_0055, 32'h0000_0055, 32'h0);

		set_limit(2047);
		repeat (310) add_random_req();

		// Sender pauses until every response has come back.
		sender_hold = 1'b1;
		while (done_cnt != sent_cnt - req_pending.size())
			@(negedge clk);
		repeat (20) @(negedge clk);
		sender_hold = 1'b0;

		set_limit(5);
		repeat (150) add_random_req();

		set_limit(1024);
		repeat (200) add_random_req();
		long_hold = 1'b1;
		repeat (200) add_random_req();

		// Fill every slot, then keep inserting more keys, with no idling on either side.
		set_limit(2047);
		quiet = 1'b1;
		for (int i = 0; i < 1060; i++)
			add_req(ACT_INSERT, (i < NSLOT) ? i : $urandom, 32'hA500_0000 | i, $urandom);
		for (int i = 0; i < 8; i++)
			add_req(ACT_SEARCH, i * 97, 32'hA500_0000 | (i * 97), 32'h0);

		wait_drained();
		repeat (100) @(posedge clk);
		$display("%0d requests checked over load limits 0, 5, 768, 1024 and 2047;", done_cnt);
		$display("%0d hits and %0d refused inserts, including a completely full table.",
			hit_cnt, full_cnt);
		if (err_cnt == 0 && rsp_expected.size() == 0) begin
			$display("open_addressing_hash_table regression: pass");
		end else begin
			$display("open_addressing_hash_table regression: fail");
		end
		$finish;
	end

endmodule

// ===== open_addressing_hash_table.f =====
hw/rtl/oaht_pkg.sv
hw/rtl/open_addressing_hash_table.sv
hw/rtl/oaht_checker.sv
verif/tb_top.sv
